// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent on the same clock edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent on the following clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/nnfd_pkg.sv -----
// Package: constants, codes and the sequencer state type of the gallery matcher.
package nnfd_pkg;

    localparam int FEATURE_DIM = 128;
    localparam int MAX_BUDGET  = 64;
    localparam int TRACK_SLOTS = 32;

    localparam int MODE_W    = 2;
    localparam int TRACK_W   = 5;
    localparam int ELEM_W    = 16;
    localparam int DIST_W    = 32;
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DROP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_METRIC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 1'd1;

    localparam logic [CFG_DAT_W-1:0] BUDGET_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_FILL,
        S_COMMIT,
        S_MIN,
        S_OUT
    } t_state;

endpackage

// ----- rtl/nnfd_ram.sv -----
// Generic simple dual-port RAM with registered read.
module nnfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/nearest_neighbor_feature_distance.sv -----
// Top level: per-track feature gallery with min cosine / squared euclidean distance.
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one request per feature
//   element: mode (load, query, drop), track, Q1.15 element and a last mark.
//   Output channel (o_out_valid / i_out_stall) returns one result per query
//   request with last set: track, Q11.20 min distance, empty flag, size.
//   Configuration writes (i_cfg_we) select the metric and the gallery budget;
//   the user must make them only while the block is idle; the block has no check.
// Sequencing
//   One shared 16x16 multiplier and one accumulator run under a sequencer.
//   A load element is written to the gallery and its square accumulated. A
//   query element takes one gallery read per stored vector of the track,
//   plus its own square. The last load element adds the zero fill and
//   commit; the last query element adds the min pass over the
//   stored norms and dot sums. One request is worked on at a time.
// Reset
//   Synchronous, active low. Track counts, ring pointers, accumulators and
//   the dot-sum valid bits clear at once; no clearing pass is run. Gallery
//   contents are undefined until written.
// Stall
//   A result sits in the output register; the next request is accepted while
//   it waits. A new result waits in the final state until the register frees.
module nearest_neighbor_feature_distance #(
    parameter int FEATURE_DIM = nnfd_pkg::FEATURE_DIM,
    parameter int MAX_BUDGET  = nnfd_pkg::MAX_BUDGET,
    parameter int TRACK_SLOTS = nnfd_pkg::TRACK_SLOTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [nnfd_pkg::MODE_W-1:0]         i_mode,
    input  logic [nnfd_pkg::TRACK_W-1:0]        i_track,
    input  logic signed [nnfd_pkg::ELEM_W-1:0]  i_element,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [nnfd_pkg::TRACK_W-1:0]        o_result_track,
    output logic signed [nnfd_pkg::DIST_W-1:0]  o_distance,
    output logic                                o_gallery_empty,
    output logic [nnfd_pkg::SIZE_W-1:0]         o_gallery_size,
    input  logic                                i_cfg_we,
    input  logic [nnfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nnfd_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

`include "assert_macros.svh"

    localparam int PW   = $clog2(FEATURE_DIM + 1);
    localparam int CW   = $clog2(MAX_BUDGET + 1);
    localparam int SW   = (MAX_BUDGET > 1) ? $clog2(MAX_BUDGET) : 1;
    localparam int TW   = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int RD   = TRACK_SLOTS * MAX_BUDGET;
    localparam int RW   = (RD > 1) ? $clog2(RD) : 1;
    localparam int GD   = RD * FEATURE_DIM;
    localparam int GW   = $clog2(GD);
    localparam int DOTW = 32 + $clog2(FEATURE_DIM);
    localparam int NW   = 31 + $clog2(FEATURE_DIM);
    localparam int DW   = DOTW + 2;
    localparam int EW   = nnfd_pkg::ELEM_W;
    localparam int PRW  = 2 * EW;

    localparam logic signed [DW-1:0] ONE_Q30 = DW'(1) << 30;
    localparam logic signed [DW:0]   ROUND_HALF = (DW + 1)'(512);
    localparam logic signed [DW:0]   SAT_HI = (DW + 1)'(32'sh7FFF_FFFF);
    localparam logic signed [DW:0]   SAT_LO = -(SAT_HI + (DW + 1)'(1));

    // ---------------- state ----------------
    nnfd_pkg::t_state r_state, n_state;

    logic                         r_metric;
    logic [nnfd_pkg::CFG_DAT_W-1:0] r_budget;
    logic [CW-1:0]                r_vcount [TRACK_SLOTS];
    logic [SW-1:0]                r_next   [TRACK_SLOTS];
    logic [MAX_BUDGET-1:0]        r_dvld;
    logic [PW-1:0]                r_pos;
    logic [NW-1:0]                r_qnorm;
    logic [NW-1:0]                r_lnorm;

    // request held during its work
    logic [nnfd_pkg::MODE_W-1:0]  r_mode;
    logic [nnfd_pkg::TRACK_W-1:0] r_t;
    logic [TW-1:0]                r_tidx;
    logic [RW-1:0]                r_row;
    logic signed [EW-1:0]         r_elem;
    logic                         r_last;
    logic                         r_inr;
    logic [CW-1:0]                r_b;
    logic [CW-1:0]                r_n;
    logic [SW-1:0]                r_slot;
    logic [CW-1:0]                r_cnt;

    // shared multiply / accumulate pipeline
    logic                         r_t1v, r_t1sq, r_t1dv;
    logic [SW-1:0]                r_t1slot;
    logic                         r_t2v, r_t2sq;
    logic [SW-1:0]                r_t2slot;
    logic signed [PRW-1:0]        r_prod;
    logic signed [DOTW-1:0]       r_dold;

    // min pass
    logic                         r_dv;
    logic signed [DW-1:0]         r_d;
    logic signed [DW-1:0]         r_best;
    logic                         r_bvalid;

    // output register
    logic                         r_ov;
    logic [nnfd_pkg::TRACK_W-1:0] r_otrack;
    logic signed [nnfd_pkg::DIST_W-1:0] r_odist;
    logic                         r_oempty;
    logic [nnfd_pkg::SIZE_W-1:0]  r_osize;

    // ---------------- accept-time decode ----------------
    logic                 in_acc;
    logic [TW-1:0]        a_tidx;
    logic                 a_trk_ok;
    logic [CW-1:0]        a_b, a_cnt, a_n;
    logic [SW-1:0]        a_slot;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign a_tidx   = TW'(i_track);
    assign a_trk_ok = (32'(i_track) < TRACK_SLOTS);

    always_comb begin
        if (r_budget == '0) begin
            a_b = CW'(1);
        end else if (32'(r_budget) > MAX_BUDGET) begin
            a_b = CW'(MAX_BUDGET);
        end else begin
            a_b = CW'(r_budget);
        end
        a_cnt = r_vcount[a_tidx];
        a_n   = (a_cnt < a_b) ? a_cnt : a_b;
        if (a_cnt < a_b) begin
            a_slot = SW'(a_cnt);
        end else if (CW'(r_next[a_tidx]) >= a_b) begin
            a_slot = '0;
        end else begin
            a_slot = r_next[a_tidx];
        end
    end

    // ---------------- sequencer control ----------------
    logic          is_load;
    logic [CW-1:0] issue_end;
    logic          issue_run, issue_min, issue_any, run_done, min_done;
    logic          out_free;
    logic [SW-1:0] cnt_slot;

    assign is_load   = (r_mode == nnfd_pkg::MODE_LOAD);
    assign issue_end = is_load ? '0 : r_n;
    assign cnt_slot  = SW'(r_cnt);
    assign issue_run = (r_state == nnfd_pkg::S_RUN) && r_inr && (r_cnt <= issue_end);
    assign issue_min = (r_state == nnfd_pkg::S_MIN) && (r_cnt < r_n);
    assign issue_any = issue_run || issue_min;
    assign run_done  = (!r_inr || (r_cnt > issue_end)) && !r_t1v && !r_t2v;
    assign min_done  = (r_cnt >= r_n) && !r_t1v && !r_dv;
    assign out_free  = !r_ov || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            nnfd_pkg::S_IDLE: begin
                if (in_acc && a_trk_ok &&
                    (i_mode == nnfd_pkg::MODE_LOAD || i_mode == nnfd_pkg::MODE_QUERY)) begin
                    n_state = nnfd_pkg::S_RUN;
                end
            end
            nnfd_pkg::S_RUN: begin
                if (run_done) begin
                    if (!r_last) begin
                        n_state = nnfd_pkg::S_IDLE;
                    end else if (is_load) begin
                        n_state = nnfd_pkg::S_FILL;
                    end else begin
                        n_state = nnfd_pkg::S_MIN;
                    end
                end
            end
            nnfd_pkg::S_FILL: begin
                if (32'(r_pos) >= FEATURE_DIM) begin
                    n_state = nnfd_pkg::S_COMMIT;
                end
            end
            nnfd_pkg::S_COMMIT: n_state = nnfd_pkg::S_IDLE;
            nnfd_pkg::S_MIN: begin
                if (min_done) begin
                    n_state = nnfd_pkg::S_OUT;
                end
            end
            nnfd_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = nnfd_pkg::S_IDLE;
                end
            end
            default: n_state = nnfd_pkg::S_IDLE;
        endcase
    end

    // ---------------- memory ports ----------------
    logic            g_we;
    logic [SW-1:0]   g_slot;
    logic [GW-1:0]   g_addr;
    logic [EW-1:0]   g_wdata, g_rdata;
    logic            d_we;
    logic [DOTW-1:0] d_wdata, d_rdata;
    logic            m_we;
    logic [RW-1:0]   m_waddr, m_raddr;
    logic [NW-1:0]   m_rdata;

    always_comb begin
        g_we    = 1'b0;
        g_wdata = r_elem;
        g_slot  = cnt_slot;
        m_we    = 1'b0;
        d_we    = r_t2v && !r_t2sq;
        case (r_state)
            nnfd_pkg::S_RUN: begin
                g_we   = issue_run && is_load;
                g_slot = is_load ? r_slot : cnt_slot;
            end
            nnfd_pkg::S_FILL: begin
                g_we    = (32'(r_pos) < FEATURE_DIM);
                g_wdata = '0;
                g_slot  = r_slot;
            end
            nnfd_pkg::S_COMMIT: m_we = 1'b1;
            default: ;
        endcase
    end

    assign g_addr  = (GW'(r_row) + GW'(g_slot)) * GW'(FEATURE_DIM) + GW'(r_pos);
    assign d_wdata = r_dold + DOTW'(r_prod);
    assign m_waddr = r_row + RW'(r_slot);
    assign m_raddr = r_row + RW'(cnt_slot);

    nnfd_ram #(.WIDTH(EW), .DEPTH(GD)) u_gallery (
        .i_clk  (i_clk),
        .i_we   (g_we),
        .i_waddr(g_addr),
        .i_wdata(g_wdata),
        .i_raddr(g_addr),
        .o_rdata(g_rdata)
    );

    nnfd_ram #(.WIDTH(DOTW), .DEPTH(MAX_BUDGET)) u_dots (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_waddr(r_t2slot),
        .i_wdata(d_wdata),
        .i_raddr(cnt_slot),
        .o_rdata(d_rdata)
    );

    nnfd_ram #(.WIDTH(NW), .DEPTH(RD)) u_norms (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(r_lnorm),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    // ---------------- datapath ----------------
    logic signed [DOTW-1:0] dot_m;
    logic signed [DW-1:0]   dot_x, d_cos, d_euc, d_sel;
    logic signed [DW:0]     q_round, q_shift;
    logic signed [nnfd_pkg::DIST_W-1:0] q_sat;
    logic signed [EW-1:0]   mul_b;

    assign mul_b = r_t1sq ? r_elem : $signed(g_rdata);
    assign dot_m = r_t1dv ? $signed(d_rdata) : '0;
    assign dot_x = DW'(dot_m);
    assign d_cos = ONE_Q30 - dot_x;

    always_comb begin
        d_euc = $signed({{(DW - NW){1'b0}}, r_qnorm}) + $signed({{(DW - NW){1'b0}}, m_rdata})
              - (dot_x <<< 1);
        if (d_euc < 0) begin
            d_euc = '0;
        end
        d_sel = r_metric ? d_euc : d_cos;
    end

    // Q.30 -> Q11.20, round half up, saturate
    always_comb begin
        q_round = (DW + 1)'(r_best) + ROUND_HALF;
        q_shift = q_round >>> 10;
        if (q_shift > SAT_HI) begin
            q_sat = nnfd_pkg::DIST_W'(SAT_HI);
        end else if (q_shift < SAT_LO) begin
            q_sat = nnfd_pkg::DIST_W'(SAT_LO);
        end else begin
            q_sat = nnfd_pkg::DIST_W'(q_shift);
        end
    end

    // pipeline payload, no reset
    always_ff @(posedge i_clk) begin
        r_t1sq   <= (r_cnt == issue_end) && (r_state == nnfd_pkg::S_RUN);
        r_t1slot <= cnt_slot;
        r_t1dv   <= r_dvld[cnt_slot];
        r_t2sq   <= r_t1sq;
        r_t2slot <= r_t1slot;
        r_prod   <= r_elem * mul_b;
        r_dold   <= dot_m;
        r_d      <= d_sel;
        if (in_acc) begin
            r_mode <= i_mode;
            r_t    <= i_track;
            r_tidx <= a_tidx;
            r_row  <= RW'(RW'(a_tidx) * RW'(MAX_BUDGET));
            r_elem <= i_element;
            r_last <= i_last;
            r_inr  <= (32'(r_pos) < FEATURE_DIM);
            r_b    <= a_b;
            r_n    <= a_n;
            r_slot <= a_slot;
        end
        if (r_state == nnfd_pkg::S_OUT && out_free) begin
            r_otrack <= r_t;
            r_oempty <= (r_n == '0);
            r_osize  <= nnfd_pkg::SIZE_W'(r_n);
            r_odist  <= (r_n == '0) ? '0 : q_sat;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nnfd_pkg::S_IDLE;
            r_metric <= 1'b0;
            r_budget <= nnfd_pkg::BUDGET_RESET;
            for (int k = 0; k < TRACK_SLOTS; k++) begin
                r_vcount[k] <= '0;
                r_next[k]   <= '0;
            end
            r_dvld   <= '0;
            r_pos    <= '0;
            r_qnorm  <= '0;
            r_lnorm  <= '0;
            r_cnt    <= '0;
            r_t1v    <= 1'b0;
            r_t2v    <= 1'b0;
            r_dv     <= 1'b0;
            r_bvalid <= 1'b0;
            r_best   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_t1v   <= issue_any;
            r_t2v   <= r_t1v && (r_state == nnfd_pkg::S_RUN);
            r_dv    <= r_t1v && (r_state == nnfd_pkg::S_MIN);

            if (i_cfg_we) begin
                case (i_cfg_index)
                    nnfd_pkg::REG_METRIC: r_metric <= i_cfg_data[0];
                    nnfd_pkg::REG_BUDGET: r_budget <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_free) begin
                r_ov <= 1'b0;
            end

            // drop request: empty the track and end the stream
            if (r_state == nnfd_pkg::S_IDLE && in_acc && a_trk_ok &&
                i_mode == nnfd_pkg::MODE_DROP) begin
                r_vcount[a_tidx] <= '0;
                r_next[a_tidx]   <= '0;
                r_dvld  <= '0;
                r_pos   <= '0;
                r_qnorm <= '0;
                r_lnorm <= '0;
            end

            if (r_state == nnfd_pkg::S_IDLE) begin
                r_cnt <= '0;
            end

            if (issue_any) begin
                r_cnt <= r_cnt + CW'(1);
            end

            // accumulate stage of the shared MAC
            if (r_t2v) begin
                if (r_t2sq) begin
                    if (is_load) begin
                        r_lnorm <= r_lnorm + NW'(r_prod);
                    end else begin
                        r_qnorm <= r_qnorm + NW'(r_prod);
                    end
                end else begin
                    r_dvld[r_t2slot] <= 1'b1;
                end
            end

            if (r_state == nnfd_pkg::S_RUN && run_done) begin
                if (r_inr) begin
                    r_pos <= r_pos + PW'(1);
                end
                r_cnt    <= '0;
                r_bvalid <= 1'b0;
            end

            if (r_state == nnfd_pkg::S_FILL && 32'(r_pos) < FEATURE_DIM) begin
                r_pos <= r_pos + PW'(1);
            end

            if (r_state == nnfd_pkg::S_COMMIT) begin
                if (r_vcount[r_tidx] < r_b) begin
                    r_vcount[r_tidx] <= r_vcount[r_tidx] + CW'(1);
                    r_next[r_tidx]   <= ((r_vcount[r_tidx] + CW'(1)) >= r_b) ? '0
                                      : SW'(r_vcount[r_tidx] + CW'(1));
                end else begin
                    r_vcount[r_tidx] <= r_b;
                    r_next[r_tidx]   <= ((CW'(r_slot) + CW'(1)) >= r_b) ? '0
                                      : SW'(CW'(r_slot) + CW'(1));
                end
            end

            if (r_dv && (!r_bvalid || r_d < r_best)) begin
                r_best   <= r_d;
                r_bvalid <= 1'b1;
            end

            if (r_state == nnfd_pkg::S_OUT && out_free) begin
                r_ov <= 1'b1;
            end

            // end of vector: commit or report clears the shared stream
            if (r_state == nnfd_pkg::S_COMMIT ||
                (r_state == nnfd_pkg::S_OUT && out_free)) begin
                r_dvld  <= '0;
                r_pos   <= '0;
                r_qnorm <= '0;
                r_lnorm <= '0;
            end
        end
    end

    // ---------------- ports ----------------
    assign o_in_stall      = (r_state != nnfd_pkg::S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_result_track  = r_otrack;
    assign o_distance      = r_odist;
    assign o_gallery_empty = r_oempty;
    assign o_gallery_size  = r_osize;

    // ---------------- assertions ----------------
    `ASSERT_IMPL(a_idle_drained, i_clk, i_rst_n, r_state == nnfd_pkg::S_IDLE,
                 !r_t1v && !r_t2v && !r_dv, "pipeline not drained in idle")
    `ASSERT_IMPL(a_out_from_seq, i_clk, i_rst_n, $rose(r_ov),
                 $past(r_state) == nnfd_pkg::S_OUT, "result not from report state")
    `ASSERT_NEXT(a_count_bound, i_clk, i_rst_n, r_state == nnfd_pkg::S_COMMIT,
                 r_vcount[r_tidx] <= r_b, "gallery count above budget")

endmodule

// ----- tb/tb.sv -----
// Testbench for the per-track feature gallery distance block.
`timescale 1ns / 1ps

module tb;

    // Mode 3 carries no operation; the block must ignore it.
    localparam logic [nnfd_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 300;   // covers a full zero fill and commit
    localparam int HOLD_CYCLES  = 2000;  // long receiver hold-off
    localparam int STUCK_LIMIT  = 20000; // cycles with no handshake at all

    typedef struct {
        logic [nnfd_pkg::TRACK_W-1:0]       trk;
        logic signed [nnfd_pkg::DIST_W-1:0] dval;
        logic                               empty;
        logic [nnfd_pkg::SIZE_W-1:0]        size;
    } t_match;

    // Holds its own copy of the galleries and predicts the match result.
    class gallery_scoreboard;
        logic signed [nnfd_pkg::ELEM_W-1:0] store [0:nnfd_pkg::TRACK_SLOTS*
                                                     nnfd_pkg::MAX_BUDGET*
                                                     nnfd_pkg::FEATURE_DIM-1];
        longint      norms [0:nnfd_pkg::TRACK_SLOTS*nnfd_pkg::MAX_BUDGET-1];
        int unsigned count [nnfd_pkg::TRACK_SLOTS];
        int unsigned ring  [nnfd_pkg::TRACK_SLOTS];
        longint      dots  [nnfd_pkg::MAX_BUDGET];
        longint      q_norm, l_norm;
        int unsigned pos;
        bit          metric;
        bit [6:0]    budget;
        t_match      pending[$];
        int          errors;

        function new();
            foreach (count[i]) begin
                count[i] = 0;
                ring[i]  = 0;
            end
            metric = 0;
            budget = nnfd_pkg::BUDGET_RESET;
            errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            pos = 0;
            q_norm = 0;
            l_norm = 0;
            foreach (dots[i]) dots[i] = 0;
        endfunction

        function void set_reg(logic [nnfd_pkg::CFG_IDX_W-1:0] idx,
                              logic [nnfd_pkg::CFG_DAT_W-1:0] data);
            if (idx == nnfd_pkg::REG_METRIC) metric = data[0];
            else if (idx == nnfd_pkg::REG_BUDGET) budget = data;
        endfunction

        function int unsigned addr(int unsigned t, int unsigned s, int unsigned p);
            return (t * nnfd_pkg::MAX_BUDGET + s) * nnfd_pkg::FEATURE_DIM + p;
        endfunction

        // Accepted request: update the model and queue any expected result.
        function void note_request(logic [nnfd_pkg::MODE_W-1:0] mode,
                                   logic [nnfd_pkg::TRACK_W-1:0] trk,
                                   logic signed [nnfd_pkg::ELEM_W-1:0] elem, logic last);
            int unsigned b, n, s, t;
            longint e, d, best, r;
            t_match m;
            t = trk;
            e = longint'(elem);
            if (mode == MODE_UNUSED) return;
            if (mode == nnfd_pkg::MODE_DROP) begin
                count[t] = 0;
                ring[t] = 0;
                clear_stream();
                return;
            end
            b = (budget < 1) ? 1 : (budget > nnfd_pkg::MAX_BUDGET) ? nnfd_pkg::MAX_BUDGET
                                                                   : budget;
            if (mode == nnfd_pkg::MODE_LOAD) begin
                if (count[t] < b) s = count[t];
                else s = (ring[t] >= b) ? 0 : ring[t];
                if (pos < nnfd_pkg::FEATURE_DIM) begin
                    store[addr(t, s, pos)] = elem;
                    l_norm += e * e;
                    pos++;
                end
                if (!last) return;
                for (int unsigned p = pos; p < nnfd_pkg::FEATURE_DIM; p++)
                    store[addr(t, s, p)] = '0;
                norms[t * nnfd_pkg::MAX_BUDGET + s] = l_norm;
                if (count[t] < b) begin
                    count[t]++;
                    ring[t] = (count[t] >= b) ? 0 : count[t];
                end else begin
                    count[t] = b;
                    ring[t] = (s + 1 >= b) ? 0 : s + 1;
                end
                clear_stream();
                return;
            end
            n = (count[t] < b) ? count[t] : b;
            if (pos < nnfd_pkg::FEATURE_DIM) begin
                for (s = 0; s < n; s++) dots[s] += e * longint'(store[addr(t, s, pos)]);
                q_norm += e * e;
                pos++;
            end
            if (!last) return;
            m.trk = trk;
            if (n == 0) begin
                m.dval = '0;
                m.empty = 1'b1;
                m.size = '0;
            end else begin
                best = 0;
                for (s = 0; s < n; s++) begin
                    if (!metric) d = (longint'(1) << 30) - dots[s];
                    else begin
                        d = q_norm + norms[t * nnfd_pkg::MAX_BUDGET + s] - 2 * dots[s];
                        if (d < 0) d = 0;
                    end
                    if (s == 0 || d < best) best = d;
                end
                r = (best + 512) >>> 10;  // floor division, round half up
                if (r > 64'sd2147483647) r = 64'sd2147483647;
                if (r < -64'sd2147483648) r = -64'sd2147483648;
                m.dval = r[nnfd_pkg::DIST_W-1:0];
                m.empty = 1'b0;
                m.size = n[nnfd_pkg::SIZE_W-1:0];
            end
            pending.push_back(m);
            clear_stream();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [nnfd_pkg::TRACK_W-1:0] trk,
                          logic signed [nnfd_pkg::DIST_W-1:0] dval,
                          logic empty, logic [nnfd_pkg::SIZE_W-1:0] size);
            t_match m;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result for track %0d", trk));
                return;
            end
            m = pending.pop_front();
            if (trk !== m.trk)
                report_mismatch($sformatf("track %0d, want %0d", trk, m.trk));
            if (dval !== m.dval)
                report_mismatch($sformatf("track %0d distance %0d, want %0d",
                                          m.trk, dval, m.dval));
            if (empty !== m.empty)
                report_mismatch($sformatf("track %0d empty %0b, want %0b",
                                          m.trk, empty, m.empty));
            if (size !== m.size)
                report_mismatch($sformatf("track %0d size %0d, want %0d",
                                          m.trk, size, m.size));
        endtask
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic [nnfd_pkg::MODE_W-1:0]        i_mode;
    logic [nnfd_pkg::TRACK_W-1:0]       i_track;
    logic signed [nnfd_pkg::ELEM_W-1:0] i_element;
    logic                               i_last;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic [nnfd_pkg::TRACK_W-1:0]       o_result_track;
    logic signed [nnfd_pkg::DIST_W-1:0] o_distance;
    logic                               o_gallery_empty;
    logic [nnfd_pkg::SIZE_W-1:0]        o_gallery_size;
    logic                               i_cfg_we;
    logic [nnfd_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [nnfd_pkg::CFG_DAT_W-1:0]     i_cfg_data;

    gallery_scoreboard sb = new();
    bit quiet;       // no idling on either side in the final stretch
    bit hold_req;    // asks the receiver for a long hold-off
    int sent;
    int stuck;

    nearest_neighbor_feature_distance dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Receiver: checks each result, stalls in random bursts or one long hold.
    initial begin
        int burst, hold;
        burst = 0;
        hold = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_result_track, o_distance, o_gallery_empty,
                                o_gallery_size);
            if (hold_req) begin
                hold_req = 0;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(0, 5);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake means the block hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            stuck <= 0;
        else if (stuck >= STUCK_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else
            stuck <= stuck + 1;
    end

    task sender_idle(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Offer one request and hold it until accepted.
    task send_req(logic [nnfd_pkg::MODE_W-1:0] mode, logic [nnfd_pkg::TRACK_W-1:0] trk,
                  logic signed [nnfd_pkg::ELEM_W-1:0] elem, logic last);
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_track <= trk;
        i_element <= elem;
        i_last <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(mode, trk, elem, last);
        sent++;
        if (!quiet && $urandom_range(0, 4) == 0) sender_idle($urandom_range(1, 6));
    endtask

    // Wait until every expected result is in and the block has gone quiet.
    task drain();
        sender_idle(1);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(logic [nnfd_pkg::CFG_IDX_W-1:0] idx,
                   logic [nnfd_pkg::CFG_DAT_W-1:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    function logic signed [nnfd_pkg::ELEM_W-1:0] pick_elem();
        case ($urandom_range(0, 15))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return nnfd_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    function logic [nnfd_pkg::TRACK_W-1:0] pick_track();
        return ($urandom_range(0, 3) == 0) ? nnfd_pkg::TRACK_W'($urandom_range(0, 31))
                                           : nnfd_pkg::TRACK_W'($urandom_range(0, 3));
    endfunction

    // One vector; a mixed one interleaves loads and queries on random tracks.
    task send_vector(logic [nnfd_pkg::MODE_W-1:0] mode, logic [nnfd_pkg::TRACK_W-1:0] trk,
                     int len, bit mixed);
        for (int i = 0; i < len; i++) begin
            if (mixed) send_req(nnfd_pkg::MODE_W'($urandom_range(0, 1)), pick_track(),
                                pick_elem(), i == len - 1);
            else send_req(mode, trk, pick_elem(), i == len - 1);
        end
    endtask

    task random_phase(int quota);
        int stop_at, r, len;
        stop_at = sent + quota;
        while (sent < stop_at) begin
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 149) == 0) ? $urandom_range(128, 131)
                                                 : $urandom_range(1, 6);
            if (r < 45) send_vector(nnfd_pkg::MODE_LOAD, pick_track(), len, 1'b0);
            else if (r < 85) send_vector(nnfd_pkg::MODE_QUERY, pick_track(), len, 1'b0);
            else if (r < 93) send_vector(nnfd_pkg::MODE_LOAD, 5'd0, len, 1'b1);
            else if (r < 97) send_req(nnfd_pkg::MODE_DROP, pick_track(), pick_elem(),
                                      1'($urandom));
            else send_req(MODE_UNUSED, pick_track(), pick_elem(), 1'($urandom));
        end
    endtask

    initial begin
        bit [6:0] budgets [7] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd8, 7'd64};
        quiet = 0;
        hold_req = 0;
        sent = 0;
        stuck = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = nnfd_pkg::MODE_LOAD;
        i_track = '0;
        i_element = '0;
        i_last = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = nnfd_pkg::REG_METRIC;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty gallery, extreme elements, both metrics.
        send_req(nnfd_pkg::MODE_QUERY, 5'd3, 16'sh0000, 1'b1);
        send_req(nnfd_pkg::MODE_LOAD, 5'd0, 16'sh7FFF, 1'b0);
        send_req(nnfd_pkg::MODE_LOAD, 5'd0, 16'sh8000, 1'b1);
        send_req(nnfd_pkg::MODE_LOAD, 5'd0, 16'sh8000, 1'b1);  // short load, zero filled
        send_req(nnfd_pkg::MODE_QUERY, 5'd0, 16'sh8000, 1'b0);
        send_req(nnfd_pkg::MODE_QUERY, 5'd0, 16'sh8000, 1'b1);
        send_req(MODE_UNUSED, 5'd0, 16'sh7FFF, 1'b1); // ignored
        send_req(nnfd_pkg::MODE_QUERY, 5'd31, 16'sh7FFF, 1'b1);
        // Aborted load: drop in the middle, then query the dropped track.
        send_req(nnfd_pkg::MODE_LOAD, 5'd31, 16'sh1234, 1'b0);
        send_req(nnfd_pkg::MODE_DROP, 5'd31, 16'sh0000, 1'b0);
        send_req(nnfd_pkg::MODE_QUERY, 5'd31, 16'sh7FFF, 1'b1);
        // Shared stream: a load ended by a query's last.
        send_req(nnfd_pkg::MODE_LOAD, 5'd0, 16'sh4000, 1'b0);
        send_req(nnfd_pkg::MODE_QUERY, 5'd0, 16'shC000, 1'b1);
        write_reg(nnfd_pkg::REG_METRIC, 7'd1);
        send_req(nnfd_pkg::MODE_QUERY, 5'd0, 16'sh7FFF, 1'b0);
        send_req(nnfd_pkg::MODE_QUERY, 5'd0, 16'sh8000, 1'b1);
        send_req(nnfd_pkg::MODE_QUERY, 5'd0, 16'sh8000, 1'b1);
        send_req(nnfd_pkg::MODE_DROP, 5'd0, 16'sh0000, 1'b1);
        send_req(nnfd_pkg::MODE_QUERY, 5'd0, 16'sh0000, 1'b1);
        write_reg(nnfd_pkg::REG_METRIC, 7'd0);

        // Long vectors: elements past the feature length are ignored.
        send_vector(nnfd_pkg::MODE_LOAD, 5'd7, nnfd_pkg::FEATURE_DIM + 2, 1'b0);
        send_vector(nnfd_pkg::MODE_QUERY, 5'd7, nnfd_pkg::FEATURE_DIM + 2, 1'b0);

        // Long receiver hold-off while queries keep coming; the input must back up.
        drain();
        hold_req = 1;
        for (int i = 0; i < 10; i++) send_req(nnfd_pkg::MODE_QUERY, 5'd7, pick_elem(), 1'b1);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            write_reg(nnfd_pkg::REG_BUDGET, budgets[ph]);
            write_reg(nnfd_pkg::REG_METRIC, 7'(ph % 2));
            if (ph == 6) quiet = 1;
            random_phase(95);
        end

        sender_idle(1);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
        if (sb.errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/nnfd_pkg.sv
rtl/nnfd_ram.sv
rtl/nearest_neighbor_feature_distance.sv
tb/tb.sv
